### rtl/core/dtpc_pkg.sv
// Shared types, register codes and the false-color ramp of the depth colorizer.
// Used by dtpc_cube, depth_to_pixel_colorizer and dtpc_checker; no dependencies.
package dtpc_pkg;

    typedef enum logic [1:0] {
        MODE_GRADIENT = 2'd0,
        MODE_GREY8    = 2'd1,
        MODE_RGBD     = 2'd2,
        MODE_RAW16    = 2'd3
    } mode_t;

    localparam logic REG_OUTPUT_MODE = 1'b0;

    localparam logic [2:0] NBYTES_GRADIENT = 3'd3;
    localparam logic [2:0] NBYTES_GREY8    = 3'd1;
    localparam logic [2:0] NBYTES_RGBD     = 3'd4;
    localparam logic [2:0] NBYTES_RAW16    = 3'd2;

    localparam int DEPTH_W = 11;
    localparam int GAMMA_W = 14;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } sample_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic rgb_t ramp(input logic [GAMMA_W-1:0] gamma);
        logic [5:0] band;
        logic [7:0] lb;
        logic [7:0] inv;
        rgb_t       c;
        band = gamma[GAMMA_W-1:8];
        lb   = gamma[7:0];
        inv  = ~lb;
        case (band)
            6'd0:    c = '{red: 8'hff, green: inv,   blue: inv};
            6'd1:    c = '{red: 8'hff, green: lb,    blue: 8'h00};
            6'd2:    c = '{red: inv,   green: 8'hff, blue: 8'h00};
            6'd3:    c = '{red: 8'h00, green: 8'hff, blue: lb};
            6'd4:    c = '{red: 8'h00, green: inv,   blue: 8'hff};
            6'd5:    c = '{red: 8'h00, green: 8'h00, blue: inv};
            default: c = '{red: 8'h00, green: 8'h00, blue: 8'h00};
        endcase
        return c;
    endfunction

endpackage

### rtl/core/depth_to_pixel_colorizer.sv
// Top level of the depth colorizer: APB mode register, cube pipeline, output stage.
// Depends on dtpc_pkg and dtpc_cube.
//
//   Channel   Handshake                  Payload
//   sample    sample_valid/sample_ready  depth_sample, video_red/green/blue
//   pixel     pixel_valid/pixel_ready    byte_zero..byte_three, valid_bytes
//   config    APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One item enters per clock while the pixel side is not stalled; each result is
// registered through the multiply stages of the cube and the color output register
// before it appears on the pixel port.
// Reset clears the mode register to the gradient and empties the pipeline.
// A stall on the pixel side holds every full stage; nothing is lost or repeated.
module depth_to_pixel_colorizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [10:0] depth_sample,
    input  logic [7:0]  video_red,
    input  logic [7:0]  video_green,
    input  logic [7:0]  video_blue,
    output logic        pixel_valid,
    input  logic        pixel_ready,
    output logic [7:0]  byte_zero,
    output logic [7:0]  byte_one,
    output logic [7:0]  byte_two,
    output logic [7:0]  byte_three,
    output logic [2:0]  valid_bytes
);

    dtpc_pkg::mode_t mode_reg;
    dtpc_pkg::sample_t in_sample, cube_sample;
    logic [dtpc_pkg::GAMMA_W-1:0] cube_gamma;
    logic cube_valid, cube_ready;

    logic       pixel_valid_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic [2:0] nb_reg;
    logic [7:0] b0_next, b1_next, b2_next, b3_next;
    logic [2:0] nb_next;

    dtpc_pkg::rgb_t ramp_rgb;
    logic [18:0] grey_prod;
    logic [7:0]  grey;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= dtpc_pkg::MODE_GRADIENT;
        else if (psel && penable && pwrite && paddr[2] == dtpc_pkg::REG_OUTPUT_MODE)
            mode_reg <= dtpc_pkg::mode_t'(pwdata[1:0]);
    end

    assign prdata = (paddr[2] == dtpc_pkg::REG_OUTPUT_MODE) ? {30'd0, mode_reg} : 32'd0;

    assign in_sample = '{depth: depth_sample, red: video_red,
                         green: video_green, blue: video_blue};

    dtpc_cube u_cube (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_valid),
        .in_ready   (sample_ready),
        .in_sample  (in_sample),
        .out_valid  (cube_valid),
        .out_ready  (cube_ready),
        .out_sample (cube_sample),
        .out_gamma  (cube_gamma)
    );

    assign cube_ready = !pixel_valid_reg || pixel_ready;

    assign ramp_rgb  = dtpc_pkg::ramp(cube_gamma);
    assign grey_prod = {cube_sample.depth, 8'd0} - {8'd0, cube_sample.depth};
    assign grey      = grey_prod[18:11];

    always_comb
    begin
        b0_next = 8'd0;
        b1_next = 8'd0;
        b2_next = 8'd0;
        b3_next = 8'd0;
        nb_next = dtpc_pkg::NBYTES_GRADIENT;
        unique case (mode_reg)
            dtpc_pkg::MODE_GRADIENT:
            begin
                b0_next = ramp_rgb.red;
                b1_next = ramp_rgb.green;
                b2_next = ramp_rgb.blue;
                nb_next = dtpc_pkg::NBYTES_GRADIENT;
            end
            dtpc_pkg::MODE_GREY8:
            begin
                b0_next = grey;
                nb_next = dtpc_pkg::NBYTES_GREY8;
            end
            dtpc_pkg::MODE_RGBD:
            begin
                b0_next = cube_sample.red;
                b1_next = cube_sample.green;
                b2_next = cube_sample.blue;
                b3_next = ~grey;
                nb_next = dtpc_pkg::NBYTES_RGBD;
            end
            dtpc_pkg::MODE_RAW16:
            begin
                b0_next = cube_sample.depth[7:0];
                b1_next = {5'd0, cube_sample.depth[10:8]};
                nb_next = dtpc_pkg::NBYTES_RAW16;
            end
            default:
            begin
                nb_next = dtpc_pkg::NBYTES_GRADIENT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_valid_reg <= 1'b0;
        else if (cube_ready)
            pixel_valid_reg <= cube_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cube_ready && cube_valid)
        begin
            b0_reg <= b0_next;
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            nb_reg <= nb_next;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign byte_zero   = b0_reg;
    assign byte_one    = b1_reg;
    assign byte_two    = b2_reg;
    assign byte_three  = b3_reg;
    assign valid_bytes = nb_reg;

endmodule

### rtl/core/dtpc_cube.sv
// Three-stage pipeline computing gamma = floor(d^3 * 9216 / 2^33) per item.
// Carries the sample alongside; depends on dtpc_pkg.
module dtpc_cube (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dtpc_pkg::sample_t             in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dtpc_pkg::sample_t             out_sample,
    output logic [dtpc_pkg::GAMMA_W-1:0]  out_gamma
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    dtpc_pkg::sample_t s1_sample_reg, s2_sample_reg, s3_sample_reg;
    logic [21:0] sq_reg;
    logic [32:0] cube_reg;
    logic [dtpc_pkg::GAMMA_W-1:0] gamma_reg;

    logic [21:0] sq_next;
    logic [32:0] cube_next;
    logic [36:0] cube_x9;
    logic [dtpc_pkg::GAMMA_W-1:0] gamma_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign sq_next    = {11'd0, in_sample.depth} * {11'd0, in_sample.depth};
    assign cube_next  = {11'd0, sq_reg} * {22'd0, s1_sample_reg.depth};
    assign cube_x9    = {1'b0, cube_reg, 3'b000} + {4'd0, cube_reg};
    assign gamma_next = cube_x9[23 +: dtpc_pkg::GAMMA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_sample_reg <= in_sample;
            sq_reg        <= sq_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sample_reg <= s1_sample_reg;
            cube_reg      <= cube_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_sample_reg <= s2_sample_reg;
            gamma_reg     <= gamma_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_sample = s3_sample_reg;
    assign out_gamma  = gamma_reg;

endmodule

### rtl/core/dtpc_checker.sv
// Port-level checks of the depth colorizer, attached to the top level by bind.
// Depends on depth_to_pixel_colorizer and dtpc_pkg.
module dtpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       sample_ready,
    input logic       pixel_valid,
    input logic       pixel_ready,
    input logic [7:0] byte_zero,
    input logic [7:0] byte_one,
    input logic [7:0] byte_two,
    input logic [7:0] byte_three,
    input logic [2:0] valid_bytes
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(byte_zero)
            && $stable(byte_one) && $stable(byte_two) && $stable(byte_three)
            && $stable(valid_bytes))
        else $error("Stalled pixel item changed.");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> valid_bytes == dtpc_pkg::NBYTES_GRADIENT
            || valid_bytes == dtpc_pkg::NBYTES_GREY8
            || valid_bytes == dtpc_pkg::NBYTES_RGBD
            || valid_bytes == dtpc_pkg::NBYTES_RAW16)
        else $error("Byte count out of range.");

    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && valid_bytes == dtpc_pkg::NBYTES_GREY8
            |-> byte_one == 8'd0 && byte_two == 8'd0 && byte_three == 8'd0)
        else $error("Unused bytes of a grey item are not zero.");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && (valid_bytes == dtpc_pkg::NBYTES_GRADIENT
            || valid_bytes == dtpc_pkg::NBYTES_RAW16) |-> byte_three == 8'd0)
        else $error("Fourth byte is not zero outside the depth mode.");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> pixel_valid && !pixel_ready)
        else $error("Input stalled while the output side can move.");

endmodule

bind depth_to_pixel_colorizer dtpc_checker u_dtpc_checker (.*);
